// ===== hdl/jc_pkg.sv =====
// shared constants and types for the jet colormap block
`default_nettype none

package jc_pkg;

    // default widths of the value path
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration register map
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_LIMIT = 2'd1;

    // jet curve centers in units of c/4: red 3, green 2, blue 1
    localparam int CENTER_RED   = 3;
    localparam int CENTER_GREEN = 2;
    localparam int CENTER_BLUE  = 1;

    // control that rides along with each item through the pipeline
    typedef struct packed {
        logic valid;
        logic is_equal;
        logic is_reversed;
    } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/jc_div_cell.sv =====
// one restoring division step of the fraction divider chain
`default_nettype none

module jc_div_cell #(
    parameter int VALUE_WIDTH = jc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = jc_pkg::FRAC_BITS_DEF,
    parameter bit FIRST       = 1'b0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire jc_pkg::ctl_t           ctl_in,
    input  wire logic [VALUE_WIDTH-1:0] rem_in,
    input  wire logic [FRAC_BITS:0]     q_in,
    input  wire logic [VALUE_WIDTH-1:0] den_in,
    output jc_pkg::ctl_t                ctl_out,
    output logic [VALUE_WIDTH-1:0]      rem_out,
    output logic [FRAC_BITS:0]          q_out,
    output logic [VALUE_WIDTH-1:0]      den_out
);

    jc_pkg::ctl_t             ctl_reg;
    logic [VALUE_WIDTH-1:0]   rem_reg;
    logic [VALUE_WIDTH-1:0]   rem_next;
    logic [FRAC_BITS:0]       q_reg;
    logic [FRAC_BITS:0]       q_next;
    logic [VALUE_WIDTH-1:0]   den_reg;
    logic [VALUE_WIDTH:0]     trial;
    logic [VALUE_WIDTH:0]     diff;
    logic                     ge;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial    = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
        q_next   = {q_in[FRAC_BITS-1:0], ge};
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            den_reg <= den_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;

endmodule

`default_nettype wire

// ===== hdl/jc_channel.sv =====
// one jet color channel: 1.5 - |4c - center|, clamped and scaled to 0..255
`default_nettype none

module jc_channel #(
    parameter int FRAC_BITS = jc_pkg::FRAC_BITS_DEF,
    parameter int CENTER    = jc_pkg::CENTER_GREEN
) (
    input  wire logic [FRAC_BITS:0] frac,
    output logic [7:0]              level
);

    localparam int TW = FRAC_BITS + 4;
    localparam logic [TW-1:0] CENTER_FX  = TW'(CENTER) << FRAC_BITS;
    localparam logic [TW-1:0] THREE_HALF = TW'(3) << (FRAC_BITS - 1);
    localparam logic [TW-1:0] ONE_FX     = TW'(1) << FRAC_BITS;

    logic [TW-1:0]          c4;
    logic signed [TW-1:0]   t;
    logic [TW-1:0]          mag;
    logic signed [TW-1:0]   val;
    logic [FRAC_BITS:0]     sat;
    logic [FRAC_BITS+8:0]   prod;

    // tent shape, clamp to [0, 1], times 255 and truncate
    always_comb
    begin
        c4  = {1'b0, frac, 2'b00};
        t   = signed'(c4 - CENTER_FX);
        mag = t[TW-1] ? ('0 - unsigned'(t)) : unsigned'(t);
        val = signed'(THREE_HALF - mag);
        if (val[TW-1])
        begin
            sat = '0;
        end
        else if (unsigned'(val) > ONE_FX)
        begin
            sat = ONE_FX[FRAC_BITS:0];
        end
        else
        begin
            sat = val[FRAC_BITS:0];
        end
        prod  = {sat, 8'h00} - {8'h00, sat};
        level = prod[FRAC_BITS+7:FRAC_BITS];
    end

endmodule

`default_nettype wire

// ===== hdl/jet_colormap.sv =====
// jet colormap top level: clamp, normalize through a divider chain, color channels
// path: clamp register, difference register, divider cells, output register
// throughput: one item per cycle; the restoring divider is a chain of FRAC_BITS + 1
// cells, one quotient bit per cell, each cell taking a new item every cycle
// the whole pipeline holds while a finished result is stalled at the output
// reset: asynchronous active low; low_limit = 0, high_limit = 1.0, pipeline empty
`default_nettype none

module jet_colormap #(
    parameter int VALUE_WIDTH = jc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = jc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]      sample_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [7:0]                              red,
    output logic [7:0]                              green,
    output logic [7:0]                              blue,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [jc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]             cfg_data
);

    localparam int NCELL = FRAC_BITS + 1;
    localparam logic [VALUE_WIDTH-1:0] HIGH_RESET = VALUE_WIDTH'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]     ONE_FRAC   = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic signed [VALUE_WIDTH-1:0] low_limit_reg;
    logic signed [VALUE_WIDTH-1:0] high_limit_reg;
    logic                          adv;

    // clamp stage
    logic                          clamp_valid_reg;
    logic signed [VALUE_WIDTH-1:0] clamp_reg;
    logic signed [VALUE_WIDTH-1:0] clamp_next;

    // difference stage
    jc_pkg::ctl_t                  diff_ctl_reg;
    jc_pkg::ctl_t                  diff_ctl_next;
    logic [VALUE_WIDTH-1:0]        num_reg;
    logic [VALUE_WIDTH-1:0]        num_next;
    logic [VALUE_WIDTH-1:0]        den_reg;
    logic [VALUE_WIDTH:0]          span;

    // divider chain taps
    jc_pkg::ctl_t                  ctl_chain [0:NCELL];
    logic [VALUE_WIDTH-1:0]        rem_chain [0:NCELL];
    logic [FRAC_BITS:0]            q_chain   [0:NCELL];
    logic [VALUE_WIDTH-1:0]        den_chain [0:NCELL];

    // channel stage
    logic [FRAC_BITS:0]            frac;
    logic [7:0]                    red_lvl;
    logic [7:0]                    green_lvl;
    logic [7:0]                    blue_lvl;
    logic                          out_valid_reg;
    logic [7:0]                    red_reg;
    logic [7:0]                    green_reg;
    logic [7:0]                    blue_reg;
    logic [7:0]                    red_next;
    logic [7:0]                    green_next;
    logic [7:0]                    blue_next;

    // pipeline moves unless a finished item is held at the output
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= '0;
            high_limit_reg <= HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == jc_pkg::REG_LOW_LIMIT)
            begin
                low_limit_reg <= cfg_data;
            end
            else if (cfg_index == jc_pkg::REG_HIGH_LIMIT)
            begin
                high_limit_reg <= cfg_data;
            end
        end
    end

    // clamp to low limit, then to high limit
    always_comb
    begin
        clamp_next = (sample_value < low_limit_reg) ? low_limit_reg : sample_value;
        if (clamp_next > high_limit_reg)
        begin
            clamp_next = high_limit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            clamp_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clamp_reg <= clamp_next;
        end
    end

    // numerator, span and the special cases
    always_comb
    begin
        span     = {high_limit_reg[VALUE_WIDTH-1], high_limit_reg}
                 - {low_limit_reg[VALUE_WIDTH-1], low_limit_reg};
        num_next = VALUE_WIDTH'(clamp_reg - low_limit_reg);
        diff_ctl_next.valid       = clamp_valid_reg;
        diff_ctl_next.is_equal    = (span == '0);
        diff_ctl_next.is_reversed = span[VALUE_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_ctl_reg <= '0;
        end
        else if (adv)
        begin
            diff_ctl_reg <= diff_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= num_next;
            den_reg <= span[VALUE_WIDTH-1:0];
        end
    end

    // divider chain: one quotient bit per cell
    assign ctl_chain[0] = diff_ctl_reg;
    assign rem_chain[0] = num_reg;
    assign q_chain[0]   = '0;
    assign den_chain[0] = den_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        jc_div_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .FIRST       (i == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_chain[i]),
            .rem_in  (rem_chain[i]),
            .q_in    (q_chain[i]),
            .den_in  (den_chain[i]),
            .ctl_out (ctl_chain[i+1]),
            .rem_out (rem_chain[i+1]),
            .q_out   (q_chain[i+1]),
            .den_out (den_chain[i+1])
        );
    end

    // fraction, forced to one for reversed limits
    assign frac = ctl_chain[NCELL].is_reversed ? ONE_FRAC : q_chain[NCELL];

    jc_channel #(.FRAC_BITS(FRAC_BITS), .CENTER(jc_pkg::CENTER_RED)) u_red (
        .frac  (frac),
        .level (red_lvl)
    );

    jc_channel #(.FRAC_BITS(FRAC_BITS), .CENTER(jc_pkg::CENTER_GREEN)) u_green (
        .frac  (frac),
        .level (green_lvl)
    );

    jc_channel #(.FRAC_BITS(FRAC_BITS), .CENTER(jc_pkg::CENTER_BLUE)) u_blue (
        .frac  (frac),
        .level (blue_lvl)
    );

    // equal limits give white
    always_comb
    begin
        red_next   = ctl_chain[NCELL].is_equal ? 8'hFF : red_lvl;
        green_next = ctl_chain[NCELL].is_equal ? 8'hFF : green_lvl;
        blue_next  = ctl_chain[NCELL].is_equal ? 8'hFF : blue_lvl;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_chain[NCELL].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // equal and reversed limits never both flagged on one item
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_chain[NCELL].valid |-> !(ctl_chain[NCELL].is_equal && ctl_chain[NCELL].is_reversed))
    else $error("equal and reversed flags both set");

    // quotient never exceeds one for an ordinary span
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_chain[NCELL].valid && !ctl_chain[NCELL].is_equal && !ctl_chain[NCELL].is_reversed
         && q_chain[NCELL][FRAC_BITS]) |-> (q_chain[NCELL][FRAC_BITS-1:0] == '0))
    else $error("fraction above one");

    // a new result only comes from an item at the end of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl_chain[NCELL].valid))
    else $error("result without item");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the jet colormap block: random and directed samples checked against a predictor
`timescale 1ns / 1ps

module tb;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 80;
    localparam logic [jc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [jc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;
    localparam logic [VW-1:0] MIN_VALUE = 32'h8000_0000;
    localparam logic [VW-1:0] MAX_VALUE = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [VW-1:0] sample_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [jc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [VW-1:0] cfg_data = '0;

    // predictor copy of the limit registers, reset values
    logic signed [VW-1:0] low_copy = '0;
    logic signed [VW-1:0] high_copy = VW'(ONE_Q);

    logic [VW-1:0] samples_todo[$];
    rgb_t colors_due[$];
    logic in_taken = 1'b0;
    int send_idle_pct = 22;
    int recv_stall_pct = 22;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    jet_colormap uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_value(sample_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // one jet channel: 1.5 - |4c - center| clamped to [0, 1], scaled by 255
    function automatic logic [7:0] jet_ramp(input longint frac, input int center);
        longint gap;
        longint level;
        gap = 4 * frac - longint'(center) * ONE_Q;
        if (gap < 0)
            gap = -gap;
        level = (3 * ONE_Q) / 2 - gap;
        if (level < 0)
            level = 0;
        if (level > ONE_Q)
            level = ONE_Q;
        return 8'((level * 255) >>> FB);
    endfunction

    // expected color for a sample under the current limits
    function automatic rgb_t jet_color(input logic signed [VW-1:0] sample);
        longint v;
        longint lo;
        longint hi;
        longint span;
        longint frac;
        rgb_t px;
        v = sample;
        lo = low_copy;
        hi = high_copy;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        span = hi - lo;
        if (span == 0)
        begin
            px = '1;
            return px;
        end
        if (span < 0)
            frac = ONE_Q;
        else
            frac = ((v - lo) <<< FB) / span;
        px.r = jet_ramp(frac, jc_pkg::CENTER_RED);
        px.g = jet_ramp(frac, jc_pkg::CENTER_GREEN);
        px.b = jet_ramp(frac, jc_pkg::CENTER_BLUE);
        return px;
    endfunction

    // random sample: mostly inside the limits, some at the edges, some anywhere
    function automatic logic [VW-1:0] pick_sample();
        int unsigned roll;
        longint lo;
        longint hi;
        longint pos;
        longint unsigned span;
        lo = low_copy;
        hi = high_copy;
        roll = $urandom_range(99);
        if (roll < 60 && hi >= lo)
        begin
            span = longint'(hi - lo + 1);
            pos = lo + longint'({$urandom, $urandom} % span);
            return pos[VW-1:0];
        end
        if (roll < 80)
        begin
            pos = (roll[0] ? lo : hi) + longint'($urandom_range(6)) - 3;
            return pos[VW-1:0];
        end
        return $urandom;
    endfunction

    // random limit pair: ordered, narrow, equal, reversed, near the extremes or small
    task automatic pick_limits(output logic signed [VW-1:0] lo, output logic signed [VW-1:0] hi);
        int unsigned roll;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
        longint top;
        roll = $urandom_range(99);
        a = $urandom;
        b = $urandom;
        if (roll < 45)
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
        else if (roll < 60)
        begin
            top = longint'(a) + longint'($urandom_range(4096));
            if (top > longint'(MAX_VALUE))
                top = longint'(MAX_VALUE);
            lo = a;
            hi = top[VW-1:0];
        end
        else if (roll < 70)
        begin
            lo = a;
            hi = a;
        end
        else if (roll < 80)
        begin
            lo = (a < b) ? b : a;
            hi = (a < b) ? a : b;
        end
        else if (roll < 90)
        begin
            lo = MIN_VALUE + $urandom_range(3);
            hi = MAX_VALUE - $urandom_range(3);
        end
        else
        begin
            lo = -$signed($urandom_range(16 * ONE_Q));
            hi = $urandom_range(16 * ONE_Q);
        end
    endtask

    // append one sample to the pending items
    task automatic add_sample(input logic [VW-1:0] s);
        samples_todo = {samples_todo, s};
    endtask

    // register write over the config channel, only while the block is idle
    task automatic set_reg(input logic [jc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [VW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            jc_pkg::REG_LOW_LIMIT: low_copy = data;
            jc_pkg::REG_HIGH_LIMIT: high_copy = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every item is sent and every color has come back
    task automatic drain();
        while (samples_todo.size() != 0 || in_valid || colors_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_channel(input string label, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    // input side: record the expected color of each accepted item
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            colors_due = {colors_due, jet_color(sample_value)};
            in_taken <= 1'b1;
        end
        else
            in_taken <= 1'b0;
    end

    // sender: holds an item until taken, idles at random between items
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (samples_todo.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                sample_value <= samples_todo.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold when one is requested
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_served <= hold_asks;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // output side: compare each accepted color with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (colors_due.size() == 0)
            begin
                $display("%0t: color item with none expected, actual %0d %0d %0d",
                         $time, red, green, blue);
                fail_count++;
            end
            else
            begin
                rgb_t want;
                want = colors_due.pop_front();
                check_channel("red", want.r, red);
                check_channel("green", want.g, green);
                check_channel("blue", want.b, blue);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits: field extremes, curve peaks and quarter points
        add_sample(MIN_VALUE);
        add_sample(MAX_VALUE);
        add_sample(32'h0000_0000);
        add_sample(32'h0001_0000);
        add_sample(32'h0000_8000);
        add_sample(32'h0000_4000);
        add_sample(32'h0000_C000);
        add_sample(32'h0000_2000);
        add_sample(32'h0000_6000);
        add_sample(32'h0000_A000);
        add_sample(32'h0000_E000);
        add_sample(32'hFFFF_FFFF);
        drain();

        // equal limits give white
        set_reg(jc_pkg::REG_LOW_LIMIT, 32'h0005_0000);
        set_reg(jc_pkg::REG_HIGH_LIMIT, 32'h0005_0000);
        add_sample(32'h0004_0000);
        add_sample(32'h0005_0000);
        add_sample(32'h0006_0000);
        drain();

        // reversed limits pin the fraction at the top
        set_reg(jc_pkg::REG_LOW_LIMIT, 32'h0001_0000);
        set_reg(jc_pkg::REG_HIGH_LIMIT, 32'hFFFF_0000);
        add_sample(32'h0000_0000);
        add_sample(MAX_VALUE);
        add_sample(MIN_VALUE);
        drain();

        // widest span, and writes to unused indexes that must change nothing
        set_reg(jc_pkg::REG_LOW_LIMIT, MIN_VALUE);
        set_reg(jc_pkg::REG_HIGH_LIMIT, MAX_VALUE);
        set_reg(REG_SPARE_A, $urandom);
        set_reg(REG_SPARE_B, $urandom);
        add_sample(MIN_VALUE);
        add_sample(MAX_VALUE);
        add_sample(32'h0000_0000);
        add_sample(32'hC000_0000);
        drain();

        // random phases with fresh limits each time
        for (int p = 0; p < 12; p++)
        begin
            pick_limits(lo, hi);
            set_reg(jc_pkg::REG_LOW_LIMIT, lo);
            set_reg(jc_pkg::REG_HIGH_LIMIT, hi);
            if ($urandom_range(3) == 0)
                set_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            send_idle_pct = 22;
            recv_stall_pct = 22;
            if (p == 2)
            begin
                // keep offering while the output is held so the pipeline backs up
                send_idle_pct = 0;
                hold_asks++;
            end
            else if (p == 5)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < 110; n++)
            begin
                add_sample(pick_sample());
                // sender pauses mid-phase until every color is back
                if (p == 7 && n == 54)
                    drain();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && colors_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== jet_colormap.f =====
hdl/jc_pkg.sv
hdl/jc_div_cell.sv
hdl/jc_channel.sv
hdl/jet_colormap.sv
test/tb.sv
